FILE: design/ordered_list_engine_macros.svh
// Assertion macros shared by the ordered list engine modules.
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// Check a consequence in the same cycle as its antecedent.
`define OLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define OLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/olist_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the ordered list engine.
package olist_pkg;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned RANGE_W  = 4;
  localparam int unsigned LEN_W    = 5;

  localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 5'd16;

  // Request action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT  = 3'd0,
    ACT_DELETE  = 3'd1,
    ACT_GET     = 3'd2,
    ACT_LOCATE  = 3'd3,
    ACT_REVERSE = 3'd4,
    ACT_CLEAR   = 3'd5
  } action_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_INSERT,
    ST_WALK,
    ST_LOCATE,
    ST_REVERSE
  } state_t;

  // Walk flavor run by the datapath on a step command
  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_INSERT,
    MODE_WALK,
    MODE_LOCATE,
    MODE_REVERSE
  } walk_mode_t;

  typedef struct packed {
    logic       load;
    logic       setup;
    logic       step;
    logic       finish;
    walk_mode_t mode;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                req_ok;
    logic                walk_done;
  } dp_status_t;

endpackage

FILE: design/olist_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the ordered list engine.
`include "ordered_list_engine_macros.svh"

module olist_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  olist_pkg::dp_status_t  status,
  output olist_pkg::ctrl_cmd_t   cmd
);

  olist_pkg::state_t state_r;
  olist_pkg::state_t state_nxt;
  logic              needs_walk;

  // Decide whether the request walks the list or finishes at once
  assign needs_walk = status.req_ok &&
                      (status.action inside {olist_pkg::ACT_INSERT, olist_pkg::ACT_DELETE,
                                             olist_pkg::ACT_GET, olist_pkg::ACT_LOCATE,
                                             olist_pkg::ACT_REVERSE});

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      olist_pkg::ST_IDLE: begin
        if (start) state_nxt = olist_pkg::ST_CHECK;
      end
      olist_pkg::ST_CHECK: begin
        if (!needs_walk) begin
          state_nxt = olist_pkg::ST_IDLE;
        end else begin
          unique case (status.action) inside
            olist_pkg::ACT_INSERT:                   state_nxt = olist_pkg::ST_INSERT;
            olist_pkg::ACT_DELETE, olist_pkg::ACT_GET: state_nxt = olist_pkg::ST_WALK;
            olist_pkg::ACT_LOCATE:                   state_nxt = olist_pkg::ST_LOCATE;
            olist_pkg::ACT_REVERSE:                  state_nxt = olist_pkg::ST_REVERSE;
            default:                                 state_nxt = olist_pkg::ST_IDLE;
          endcase
        end
      end
      olist_pkg::ST_INSERT, olist_pkg::ST_WALK, olist_pkg::ST_LOCATE,
      olist_pkg::ST_REVERSE: begin
        if (status.walk_done) state_nxt = olist_pkg::ST_IDLE;
      end
      default: state_nxt = olist_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      olist_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      olist_pkg::ST_CHECK: begin
        cmd.setup  = needs_walk;
        cmd.finish = !needs_walk;
      end
      olist_pkg::ST_INSERT: begin
        cmd.step   = 1'b1;
        cmd.mode   = olist_pkg::MODE_INSERT;
        cmd.finish = status.walk_done;
      end
      olist_pkg::ST_WALK: begin
        cmd.step   = 1'b1;
        cmd.mode   = olist_pkg::MODE_WALK;
        cmd.finish = status.walk_done;
      end
      olist_pkg::ST_LOCATE: begin
        cmd.step   = 1'b1;
        cmd.mode   = olist_pkg::MODE_LOCATE;
        cmd.finish = status.walk_done;
      end
      olist_pkg::ST_REVERSE: begin
        cmd.step   = 1'b1;
        cmd.mode   = olist_pkg::MODE_REVERSE;
        cmd.finish = status.walk_done;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= olist_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `OLE_ASSERT_NEXT(a_start_to_check, state_r == olist_pkg::ST_IDLE && start, state_r == olist_pkg::ST_CHECK, "accepted request did not enter check")
  `OLE_ASSERT_NEXT(a_check_once, state_r == olist_pkg::ST_CHECK, state_r != olist_pkg::ST_CHECK, "check state repeated")
  `OLE_ASSERT_NEXT(a_finish_idle, cmd.finish, state_r == olist_pkg::ST_IDLE, "finished request left controller busy")

endmodule

FILE: design/olist_dp.sv
`timescale 1ns / 1ps
// Datapath of the ordered list engine: list memory, pointers and result registers.
`include "ordered_list_engine_macros.svh"

module olist_dp #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  olist_pkg::ctrl_cmd_t                 cmd,
  output olist_pkg::dp_status_t                status,
  input  logic [olist_pkg::ACTION_W-1:0]       in_action,
  input  logic [olist_pkg::POS_W-1:0]          in_position,
  input  logic signed [olist_pkg::VAL_W-1:0]   in_value,
  input  logic [olist_pkg::RANGE_W-1:0]        in_range_first,
  input  logic [olist_pkg::RANGE_W-1:0]        in_range_last,
  input  logic                                 cfg_we,
  input  logic [olist_pkg::LEN_W-1:0]          cfg_wdata,
  output logic                                 out_valid,
  output logic                                 out_ok,
  output logic signed [olist_pkg::VAL_W-1:0]   out_value_out,
  output logic [olist_pkg::POS_W-1:0]          out_found_position,
  output logic [olist_pkg::LEN_W-1:0]          out_list_length
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CMPW  = ((CW > olist_pkg::POS_W) ? CW : olist_pkg::POS_W) + 1;
  localparam int VOUTW = olist_pkg::VAL_W;
  localparam int LENW  = olist_pkg::LEN_W;
  localparam int FPW   = olist_pkg::POS_W;

  // List memory
  logic [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] rd_data_r;
  logic                   rd_en, wr_en;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;

  // Latched request
  logic [olist_pkg::ACTION_W-1:0] req_action_r;
  logic [olist_pkg::POS_W-1:0]    req_pos_r;
  logic [VALUE_WIDTH-1:0]         req_val_r;
  logic [olist_pkg::RANGE_W-1:0]  req_first_r, req_last_r;

  // List state and limit register
  logic [CW-1:0]   count_r, count_nxt;
  logic [LENW-1:0] max_len_r;

  // Walk registers
  logic [AW-1:0]          rd_ptr_r, rd_ptr_nxt, wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]          left_r, left_nxt;
  logic                   pend_r, pend_nxt, first_r, first_nxt;
  logic [AW-1:0]          cmp_r, cmp_nxt;
  logic [VALUE_WIDTH-1:0] vout_r, vout_nxt;
  logic [AW-1:0]          a_r, a_nxt, b_r, b_nxt, wa_r, wa_nxt, wb_r, wb_nxt;
  logic                   ph_r, ph_nxt, pend_b_r, pend_b_nxt, wb_pend_r, wb_pend_nxt;
  logic [VALUE_WIDTH-1:0] temp_r, temp_nxt;

  // Result registers
  logic             out_valid_r, ok_r;
  logic [VOUTW-1:0] value_r;
  logic [FPW-1:0]   found_r;
  logic [LENW-1:0]  len_r;

  logic [CMPW-1:0] pos_w, count_w, limit_w, first_w, last_w, max_w, idx_full;
  logic [AW-1:0]   idx;
  logic [CW-1:0]   cnt_m1, cmp_p1;
  logic            req_ok, hit, walk_done, ok_res;
  logic [VOUTW-1:0] value_res;
  logic [FPW-1:0]   found_res;

  // Validate the request against the current length and limit
  assign pos_w    = CMPW'(req_pos_r);
  assign count_w  = CMPW'(count_r);
  assign first_w  = CMPW'(req_first_r);
  assign last_w   = CMPW'(req_last_r);
  assign max_w    = CMPW'(max_len_r);
  assign limit_w  = (max_w < CMPW'(CAPACITY)) ? max_w : CMPW'(CAPACITY);
  assign idx_full = pos_w - CMPW'(1);
  assign idx      = idx_full[AW-1:0];
  assign cnt_m1   = count_r - CW'(1);

  always_comb begin
    unique case (req_action_r)
      olist_pkg::ACT_INSERT:
        req_ok = (pos_w >= CMPW'(1)) && (pos_w <= count_w + CMPW'(1)) && (count_w < limit_w);
      olist_pkg::ACT_DELETE, olist_pkg::ACT_GET:
        req_ok = (pos_w >= CMPW'(1)) && (pos_w <= count_w);
      olist_pkg::ACT_LOCATE:  req_ok = 1'b1;
      olist_pkg::ACT_REVERSE: req_ok = (first_w <= last_w) && (last_w < count_w);
      olist_pkg::ACT_CLEAR:   req_ok = 1'b1;
      default:                req_ok = 1'b0;
    endcase
  end

  // Match on the entry read last cycle
  assign hit    = pend_r && (rd_data_r == req_val_r);
  assign cmp_p1 = CW'(cmp_r) + CW'(1);

  // Detect the last step of the current walk
  always_comb begin
    unique case (cmd.mode)
      olist_pkg::MODE_INSERT, olist_pkg::MODE_WALK:
        walk_done = (left_r == '0) && !pend_r;
      olist_pkg::MODE_LOCATE:
        walk_done = hit || ((left_r == '0) && !pend_r);
      olist_pkg::MODE_REVERSE:
        walk_done = !ph_r && !(a_r < b_r) && !pend_r && !pend_b_r && !wb_pend_r;
      default:
        walk_done = 1'b0;
    endcase
  end

  assign status.action    = req_action_r;
  assign status.req_ok    = req_ok;
  assign status.walk_done = walk_done;

  // Set up and advance the walk, drive the memory ports
  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = rd_ptr_r;
    wr_en       = 1'b0;
    wr_addr     = wr_ptr_r;
    wr_data     = rd_data_r;
    rd_ptr_nxt  = rd_ptr_r;
    wr_ptr_nxt  = wr_ptr_r;
    left_nxt    = left_r;
    pend_nxt    = pend_r;
    first_nxt   = first_r;
    cmp_nxt     = cmp_r;
    vout_nxt    = vout_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    wa_nxt      = wa_r;
    wb_nxt      = wb_r;
    ph_nxt      = ph_r;
    pend_b_nxt  = pend_b_r;
    wb_pend_nxt = wb_pend_r;
    temp_nxt    = temp_r;
    if (cmd.setup) begin
      pend_nxt    = 1'b0;
      pend_b_nxt  = 1'b0;
      wb_pend_nxt = 1'b0;
      ph_nxt      = 1'b0;
      first_nxt   = 1'b1;
      cmp_nxt     = '0;
      a_nxt       = AW'(req_first_r);
      b_nxt       = AW'(req_last_r);
      unique case (req_action_r)
        olist_pkg::ACT_INSERT: begin
          rd_ptr_nxt = cnt_m1[AW-1:0];
          wr_ptr_nxt = count_r[AW-1:0];
          left_nxt   = count_r - CW'(idx);
        end
        olist_pkg::ACT_DELETE: begin
          rd_ptr_nxt = idx;
          wr_ptr_nxt = idx;
          left_nxt   = count_r - CW'(idx);
        end
        olist_pkg::ACT_GET: begin
          rd_ptr_nxt = idx;
          left_nxt   = CW'(1);
        end
        olist_pkg::ACT_LOCATE: begin
          rd_ptr_nxt = '0;
          left_nxt   = count_r;
        end
        default: begin
          left_nxt = '0;
        end
      endcase
    end else if (cmd.step) begin
      unique case (cmd.mode)
        // Shift entries up from the tail, then drop the new value in
        olist_pkg::MODE_INSERT: begin
          pend_nxt = 1'b0;
          if (left_r != '0) begin
            rd_en      = 1'b1;
            rd_ptr_nxt = rd_ptr_r - AW'(1);
            left_nxt   = left_r - CW'(1);
            pend_nxt   = 1'b1;
          end
          if (pend_r) begin
            wr_en      = 1'b1;
            wr_ptr_nxt = wr_ptr_r - AW'(1);
          end else if (left_r == '0) begin
            wr_en   = 1'b1;
            wr_data = req_val_r;
          end
        end
        // Capture the first entry read, shift the rest down by one
        olist_pkg::MODE_WALK: begin
          pend_nxt = 1'b0;
          if (left_r != '0) begin
            rd_en      = 1'b1;
            rd_ptr_nxt = rd_ptr_r + AW'(1);
            left_nxt   = left_r - CW'(1);
            pend_nxt   = 1'b1;
          end
          if (pend_r) begin
            if (first_r) begin
              vout_nxt  = rd_data_r;
              first_nxt = 1'b0;
            end else begin
              wr_en      = 1'b1;
              wr_ptr_nxt = wr_ptr_r + AW'(1);
            end
          end
        end
        // Scan from the head until the first match
        olist_pkg::MODE_LOCATE: begin
          pend_nxt = 1'b0;
          if ((left_r != '0) && !hit) begin
            rd_en      = 1'b1;
            rd_ptr_nxt = rd_ptr_r + AW'(1);
            left_nxt   = left_r - CW'(1);
            pend_nxt   = 1'b1;
          end
          if (pend_r && !hit) cmp_nxt = cmp_r + AW'(1);
        end
        // Alternate reads of the low and high ends, write back swapped
        olist_pkg::MODE_REVERSE: begin
          if (!ph_r) begin
            pend_b_nxt = 1'b0;
            pend_nxt   = 1'b0;
            if (a_r < b_r) begin
              rd_en    = 1'b1;
              rd_addr  = a_r;
              wa_nxt   = a_r;
              ph_nxt   = 1'b1;
              pend_nxt = 1'b1;
            end
          end else begin
            rd_en      = 1'b1;
            rd_addr    = b_r;
            wb_nxt     = b_r;
            a_nxt      = a_r + AW'(1);
            b_nxt      = b_r - AW'(1);
            ph_nxt     = 1'b0;
            pend_b_nxt = 1'b1;
            pend_nxt   = 1'b0;
          end
          if (pend_r) temp_nxt = rd_data_r;
          wb_pend_nxt = pend_b_r;
          if (pend_b_r) begin
            wr_en   = 1'b1;
            wr_addr = wa_r;
            wr_data = rd_data_r;
          end
          if (wb_pend_r) begin
            wr_en   = 1'b1;
            wr_addr = wb_r;
            wr_data = temp_r;
          end
        end
        default: begin
          pend_nxt = pend_r;
        end
      endcase
    end
  end

  // Length after the request and the result fields
  always_comb begin
    count_nxt = count_r;
    if (cmd.finish) begin
      unique case (req_action_r)
        olist_pkg::ACT_INSERT: if (req_ok) count_nxt = count_r + CW'(1);
        olist_pkg::ACT_DELETE: if (req_ok) count_nxt = count_r - CW'(1);
        olist_pkg::ACT_CLEAR:  count_nxt = '0;
        default:               count_nxt = count_r;
      endcase
    end
  end

  assign ok_res    = (req_action_r == olist_pkg::ACT_LOCATE) ? hit : req_ok;
  assign value_res = (req_ok && ((req_action_r == olist_pkg::ACT_DELETE) ||
                                 (req_action_r == olist_pkg::ACT_GET))) ?
                     VOUTW'(vout_r) : '0;
  assign found_res = ((req_action_r == olist_pkg::ACT_LOCATE) && hit) ? FPW'(cmp_p1) : '0;

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      max_len_r   <= olist_pkg::MAX_LENGTH_RESET;
      out_valid_r <= 1'b0;
      left_r      <= '0;
      pend_r      <= 1'b0;
      first_r     <= 1'b0;
      ph_r        <= 1'b0;
      pend_b_r    <= 1'b0;
      wb_pend_r   <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      if (cfg_we) max_len_r <= cfg_wdata;
      out_valid_r <= cmd.finish;
      left_r      <= left_nxt;
      pend_r      <= pend_nxt;
      first_r     <= first_nxt;
      ph_r        <= ph_nxt;
      pend_b_r    <= pend_b_nxt;
      wb_pend_r   <= wb_pend_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_action_r <= in_action;
      req_pos_r    <= in_position;
      req_val_r    <= VALUE_WIDTH'($unsigned(in_value));
      req_first_r  <= in_range_first;
      req_last_r   <= in_range_last;
    end
    rd_ptr_r <= rd_ptr_nxt;
    wr_ptr_r <= wr_ptr_nxt;
    cmp_r    <= cmp_nxt;
    vout_r   <= vout_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    wa_r     <= wa_nxt;
    wb_r     <= wb_nxt;
    temp_r   <= temp_nxt;
    if (cmd.finish) begin
      ok_r    <= ok_res;
      value_r <= value_res;
      found_r <= found_res;
      len_r   <= LENW'(count_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ok             = ok_r;
  assign out_value_out      = $signed(value_r);
  assign out_found_position = found_r;
  assign out_list_length    = len_r;

  `OLE_ASSERT_NEXT(a_strobe_single, out_valid_r, !out_valid_r, "result strobe held for two cycles")
  `OLE_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(CAPACITY), "list length above capacity")
  `OLE_ASSERT_NEXT(a_insert_grows, cmd.finish && (req_action_r == olist_pkg::ACT_INSERT) && req_ok, count_r == $past(count_r) + CW'(1), "successful insert did not grow list")

endmodule

FILE: design/ordered_list_engine.sv
`timescale 1ns / 1ps
// Top level of the ordered list engine.
//
// Keeps an ordered list of signed values with a length count. A request is
// taken at a clock edge where start is high and busy is low; in_action picks
// insert, delete, get, locate, reverse or clear, with in_position,
// in_value, in_range_first and in_range_last as operands. Codes 6 and 7
// change nothing and report failure.
// Each request gives exactly one result, shown for a single cycle while
// out_valid is high: out_ok, out_value_out, out_found_position and
// out_list_length (the length after the request). The receiver cannot
// stall; a result must be taken in the cycle it is shown.
// Rejections and clear finish from the check state; insert, delete, get,
// locate and reverse walk the list first. The list memory has one read and
// one write port and the walk moves one entry per cycle (reverse reads both
// ends of a pair in turn), so one request is in work at a time; busy is
// high until it finishes. cfg_we/cfg_wdata write the length limit; the user
// must write it only while idle; the block does not enforce it. Synchronous
// reset empties the list and sets the limit to 16; the memory is not cleared.
module ordered_list_engine #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [olist_pkg::ACTION_W-1:0]      in_action,
  input  logic [olist_pkg::POS_W-1:0]         in_position,
  input  logic signed [olist_pkg::VAL_W-1:0]  in_value,
  input  logic [olist_pkg::RANGE_W-1:0]       in_range_first,
  input  logic [olist_pkg::RANGE_W-1:0]       in_range_last,
  input  logic                                cfg_we,
  input  logic [olist_pkg::LEN_W-1:0]         cfg_wdata,
  output logic                                out_valid,
  output logic                                out_ok,
  output logic signed [olist_pkg::VAL_W-1:0]  out_value_out,
  output logic [olist_pkg::POS_W-1:0]         out_found_position,
  output logic [olist_pkg::LEN_W-1:0]         out_list_length
);

  olist_pkg::ctrl_cmd_t  cmd;
  olist_pkg::dp_status_t status;

  // Sequence each request
  olist_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // Hold the list and form results
  olist_dp #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_action          (in_action),
    .in_position        (in_position),
    .in_value           (in_value),
    .in_range_first     (in_range_first),
    .in_range_last      (in_range_last),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_ok             (out_ok),
    .out_value_out      (out_value_out),
    .out_found_position (out_found_position),
    .out_list_length    (out_list_length)
  );

endmodule

FILE: sim/tb_ordered_list_engine.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ordered list engine: directed and random requests.
module tb_ordered_list_engine;
  import olist_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 2 * CAPACITY + 8;

  // Action codes the block does not define
  localparam logic [ACTION_W-1:0] ACT_RSVD_A = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_RSVD_B = 3'd7;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        found;
    logic [LEN_W-1:0]        length;
  } list_result_t;

  logic                       clk;
  logic                       rst_n          = 1'b0;
  logic                       start          = 1'b0;
  logic                       busy;
  logic [ACTION_W-1:0]        in_action      = '0;
  logic [POS_W-1:0]           in_position    = '0;
  logic signed [VAL_W-1:0]    in_value       = '0;
  logic [RANGE_W-1:0]         in_range_first = '0;
  logic [RANGE_W-1:0]         in_range_last  = '0;
  logic                       cfg_we         = 1'b0;
  logic [LEN_W-1:0]           cfg_wdata      = '0;
  logic                       out_valid;
  logic                       out_ok;
  logic signed [VAL_W-1:0]    out_value_out;
  logic [POS_W-1:0]           out_found_position;
  logic [LEN_W-1:0]           out_list_length;

  // Shadow copy of the list, its length and the length limit
  logic signed [VAL_W-1:0] shadow_list [CAPACITY];
  int unsigned             shadow_len;
  logic [LEN_W-1:0]        shadow_limit;

  list_result_t expected_results[$];
  int error_count    = 0;
  int cycle_count    = 0;
  int requests_sent  = 0;
  int results_seen   = 0;
  int ok_count       = 0;
  int limit_refusals = 0;
  int full_hits      = 0;
  int limit_writes   = 0;
  bit no_idle        = 1'b0;

  ordered_list_engine #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VAL_W)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_position        (in_position),
    .in_value           (in_value),
    .in_range_first     (in_range_first),
    .in_range_last      (in_range_last),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_ok             (out_ok),
    .out_value_out      (out_value_out),
    .out_found_position (out_found_position),
    .out_list_length    (out_list_length)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one request to the shadow list and return the result it should give
  function automatic list_result_t predict_list_result(
    logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos, logic signed [VAL_W-1:0] val,
    logic [RANGE_W-1:0] first, logic [RANGE_W-1:0] last);
    list_result_t r;
    int unsigned  lim;
    int           p;
    int           a;
    int           b;
    logic signed [VAL_W-1:0] tmp;
    r   = '0;
    p   = pos;
    lim = (shadow_limit < CAPACITY) ? shadow_limit : CAPACITY;
    case (act)
      ACT_INSERT: begin
        if (p >= 1 && p <= shadow_len + 1 && shadow_len < lim) begin
          for (int j = shadow_len; j > p - 1; j--) shadow_list[j] = shadow_list[j-1];
          shadow_list[p-1] = val;
          shadow_len++;
          r.ok = 1'b1;
          if (shadow_len == CAPACITY) full_hits++;
        end else if (p >= 1 && p <= shadow_len + 1) begin
          limit_refusals++;
        end
      end
      ACT_DELETE: begin
        if (p >= 1 && p <= shadow_len) begin
          r.value = shadow_list[p-1];
          for (int j = p; j < shadow_len; j++) shadow_list[j-1] = shadow_list[j];
          shadow_len--;
          r.ok = 1'b1;
        end
      end
      ACT_GET: begin
        if (p >= 1 && p <= shadow_len) begin
          r.value = shadow_list[p-1];
          r.ok    = 1'b1;
        end
      end
      ACT_LOCATE: begin
        for (int j = 0; j < shadow_len; j++) begin
          if (!r.ok && shadow_list[j] == val) begin
            r.found = j + 1;
            r.ok    = 1'b1;
          end
        end
      end
      ACT_REVERSE: begin
        if (first <= last && last < shadow_len) begin
          a = first;
          b = last;
          while (a < b) begin
            tmp            = shadow_list[a];
            shadow_list[a] = shadow_list[b];
            shadow_list[b] = tmp;
            a++;
            b--;
          end
          r.ok = 1'b1;
        end
      end
      ACT_CLEAR: begin
        shadow_len = 0;
        r.ok       = 1'b1;
      end
      default: ;
    endcase
    r.length = shadow_len;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("[%0t] MISMATCH on result %0d, %s: expected %0d, got %0d",
             $realtime, results_seen, what, want, got);
    error_count++;
  endtask

  // Hold one request until accepted, then, unless no_idle is set, idle the request side at random
  task automatic send_request(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                              logic signed [VAL_W-1:0] val,
                              logic [RANGE_W-1:0] first, logic [RANGE_W-1:0] last);
    list_result_t want;
    int           gap;
    start          <= 1'b1;
    in_action      <= act;
    in_position    <= pos;
    in_value       <= val;
    in_range_first <= first;
    in_range_last  <= last;
    do @(posedge clk); while (busy);
    want = predict_list_result(act, pos, val, first, last);
    expected_results.push_back(want);
    requests_sent++;
    if (want.ok) ok_count++;
    gap = 0;
    if (!no_idle) while ($urandom_range(99) < 19) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and wait until every result is back and the block is idle
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_max_length(logic [LEN_W-1:0] limit);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we       <= 1'b0;
    shadow_limit  = limit;
    limit_writes++;
  endtask

  // Favor values that repeat so that locate sees duplicates
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return $urandom_range(3) - 1;
      default: return $urandom;
    endcase
  endfunction

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("[%0t] MISMATCH: result with no request outstanding", $realtime);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_ok !== want.ok) report_mismatch("ok", want.ok, out_ok);
        if (out_value_out !== want.value)
          report_mismatch("value_out", want.value, out_value_out);
        if (out_found_position !== want.found)
          report_mismatch("found_position", want.found, out_found_position);
        if (out_list_length !== want.length)
          report_mismatch("list_length", want.length, out_list_length);
      end
      results_seen++;
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0t] TIMEOUT after %0d cycles, %0d results outstanding",
               $realtime, cycle_count, expected_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Get, delete, locate, reverse and insert on an empty list, plus bad positions and an undefined code
  task automatic test_empty_list();
    send_request(ACT_GET, 5'd1, '0, 4'd0, 4'd0);
    send_request(ACT_DELETE, 5'd1, '0, 4'd0, 4'd0);
    send_request(ACT_LOCATE, 5'd0, '0, 4'd0, 4'd0);
    send_request(ACT_REVERSE, 5'd0, '0, 4'd0, 4'd0);
    send_request(ACT_INSERT, 5'd0, 32'sd5, 4'd0, 4'd0);
    send_request(ACT_INSERT, 5'd2, 32'sd5, 4'd0, 4'd0);
    send_request(ACT_RSVD_A, 5'd1, 32'sd5, 4'd0, 4'd0);
  endtask

  // Edit, read and search with extreme values and out-of-range operands
  task automatic test_edit_actions();
    send_request(ACT_INSERT, 5'd1, VAL_MIN, 4'd0, 4'd0);
    send_request(ACT_INSERT, 5'd2, VAL_MAX, 4'd0, 4'd0);
    send_request(ACT_INSERT, 5'd2, 32'sd0, 4'd0, 4'd0);
    send_request(ACT_INSERT, 5'd4, VAL_MAX, 4'd0, 4'd0);
    send_request(ACT_LOCATE, 5'd0, VAL_MAX, 4'd0, 4'd0);
    send_request(ACT_GET, 5'd3, '0, 4'd0, 4'd0);
    send_request(ACT_GET, 5'd5, '0, 4'd0, 4'd0);
    send_request(ACT_GET, 5'd31, '1, 4'd15, 4'd15);
    send_request(ACT_DELETE, 5'd4, '0, 4'd0, 4'd0);
    send_request(ACT_DELETE, 5'd0, '0, 4'd0, 4'd0);
    send_request(ACT_REVERSE, 5'd0, '0, 4'd0, 4'd2);
    send_request(ACT_REVERSE, 5'd0, '0, 4'd2, 4'd1);
    send_request(ACT_REVERSE, 5'd0, '0, 4'd1, 4'd3);
    send_request(ACT_REVERSE, 5'd0, '0, 4'd15, 4'd15);
    send_request(ACT_LOCATE, 5'd0, 32'sd12345, 4'd0, 4'd0);
    send_request(ACT_RSVD_B, 5'd2, VAL_MIN, 4'd3, 4'd2);
    send_request(ACT_CLEAR, 5'd0, '0, 4'd0, 4'd0);
  endtask

  // Inserts against a limit of one, zero, and above capacity
  task automatic test_length_limit();
    write_max_length(5'd1);
    send_request(ACT_INSERT, 5'd1, 32'sd7, 4'd0, 4'd0);
    send_request(ACT_INSERT, 5'd1, 32'sd8, 4'd0, 4'd0);
    write_max_length(5'd0);
    send_request(ACT_INSERT, 5'd2, 32'sd9, 4'd0, 4'd0);
    send_request(ACT_GET, 5'd1, '0, 4'd0, 4'd0);
    write_max_length(5'd31);
    send_request(ACT_INSERT, 5'd2, 32'sd9, 4'd0, 4'd0);
  endtask

  // Random requests, mostly with operands that pass the range checks
  task automatic test_random_traffic(logic [LEN_W-1:0] limit, int count, int insert_pct,
                                     bit quiet);
    logic [ACTION_W-1:0]     act;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    logic [RANGE_W-1:0]      first;
    logic [RANGE_W-1:0]      last;
    int                      pick;
    write_max_length(limit);
    no_idle = quiet;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < insert_pct) begin
        act = ACT_INSERT;
      end else begin
        pick = $urandom_range(99);
        if (pick < 30)      act = ACT_DELETE;
        else if (pick < 50) act = ACT_GET;
        else if (pick < 70) act = ACT_LOCATE;
        else if (pick < 92) act = ACT_REVERSE;
        else if (pick < 96) act = ACT_CLEAR;
        else                act = $urandom_range(1) ? ACT_RSVD_A : ACT_RSVD_B;
      end
      if ($urandom_range(99) < 12)
        pos = $urandom_range(31);
      else if (act == ACT_INSERT)
        pos = $urandom_range(shadow_len + 1, 1);
      else
        pos = (shadow_len == 0) ? 5'd1 : $urandom_range(shadow_len, 1);
      if (act == ACT_LOCATE && shadow_len > 0 && $urandom_range(99) < 60)
        val = shadow_list[$urandom_range(shadow_len - 1)];
      else
        val = pick_value();
      if (shadow_len > 0 && $urandom_range(99) < 80) begin
        first = $urandom_range(shadow_len - 1);
        last  = $urandom_range(shadow_len - 1, first);
      end else begin
        first = $urandom_range(15);
        last  = $urandom_range(15);
      end
      send_request(act, pos, val, first, last);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    shadow_len   = 0;
    shadow_limit = MAX_LENGTH_RESET;
    foreach (shadow_list[i]) shadow_list[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_edit_actions();
    test_length_limit();
    test_random_traffic(5'd16, 220, 45, 1'b0);
    test_random_traffic(5'd31, 220, 60, 1'b1);
    test_random_traffic(5'd0, 150, 30, 1'b0);
    test_random_traffic(5'd1, 150, 40, 1'b0);
    test_random_traffic($urandom_range(15, 2), 250, 50, 1'b0);
    test_random_traffic(5'd16, 260, 70, 1'b0);

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("MISMATCH: %0d results never arrived", expected_results.size());
      error_count++;
    end
    $display("Ran %0d requests over %0d limit settings: %0d succeeded, %0d results compared",
             requests_sent, limit_writes, ok_count, results_seen);
    $display("List filled to capacity %0d times; %0d inserts refused by the length limit",
             full_hits, limit_refusals);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
